[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ARPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from one cycle to the next
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    `ARPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/arpc_pkg.sv]
// types, constants and microcode table of the arp cache
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_EVICT
    } step_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_SCAN,
        OP_EMIT_HIT,
        OP_EMIT_MISS,
        OP_EMIT_EVICT
    } uc_op_t;

    typedef struct packed {
        uc_op_t op;
        step_t  tgt_a;
        step_t  tgt_b;
        step_t  tgt_c;
    } uc_word_t;

    typedef struct packed {
        logic in_fire;
        logic match;
        logic last;
        logic add;
        logic out_free;
    } cond_t;

    typedef struct packed {
        uc_op_t op;
        logic   emit;
    } ctrl_t;

    function automatic uc_word_t uc_rom(input step_t step);
        uc_word_t w;
        w = '{op: OP_WAIT, tgt_a: ST_IDLE, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
        case (step)
            ST_IDLE:  w = '{op: OP_WAIT, tgt_a: ST_SCAN, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
            ST_SCAN:  w = '{op: OP_SCAN, tgt_a: ST_HIT, tgt_b: ST_MISS, tgt_c: ST_EVICT};
            ST_HIT:   w = '{op: OP_EMIT_HIT, tgt_a: ST_IDLE, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
            ST_MISS:  w = '{op: OP_EMIT_MISS, tgt_a: ST_IDLE, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
            ST_EVICT: w = '{op: OP_EMIT_EVICT, tgt_a: ST_IDLE, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
            default:  w = '{op: OP_WAIT, tgt_a: ST_IDLE, tgt_b: ST_IDLE, tgt_c: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/arpc_table.sv]
// entry storage with per-entry valid bits and registered read
module arpc_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [IW-1:0]               rd_addr,
    output logic [arpc_pkg::IP_W-1:0]   rd_ip,
    output logic [arpc_pkg::MAC_W-1:0]  rd_mac,
    output logic [arpc_pkg::TIME_W-1:0] rd_time,
    input  logic                        wr_en,
    input  logic [IW-1:0]               wr_addr,
    input  logic [arpc_pkg::IP_W-1:0]   wr_ip,
    input  logic [arpc_pkg::MAC_W-1:0]  wr_mac,
    input  logic [arpc_pkg::TIME_W-1:0] wr_time
);

    logic [arpc_pkg::IP_W-1:0]   ip_mem   [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0]  mac_mem  [ENTRIES];
    logic [arpc_pkg::TIME_W-1:0] time_mem [ENTRIES];
    logic [ENTRIES-1:0]          vld_reg;

    logic                        rd_vld_reg;
    logic [arpc_pkg::IP_W-1:0]   rd_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  rd_mac_reg;
    logic [arpc_pkg::TIME_W-1:0] rd_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ip_mem[wr_addr]   <= wr_ip;
            mac_mem[wr_addr]  <= wr_mac;
            time_mem[wr_addr] <= wr_time;
        end
        rd_ip_reg   <= ip_mem[rd_addr];
        rd_mac_reg  <= mac_mem[rd_addr];
        rd_time_reg <= time_mem[rd_addr];
    end

    // entries never written read as the cleared value
    assign rd_ip   = rd_vld_reg ? rd_ip_reg   : '0;
    assign rd_mac  = rd_vld_reg ? rd_mac_reg  : '0;
    assign rd_time = rd_vld_reg ? rd_time_reg : '0;

endmodule

[rtl/arpc_seq.sv]
// microcode sequencer: step register, control rom and jumps
module arpc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  arpc_pkg::cond_t cond,
    output arpc_pkg::ctrl_t ctrl
);

    arpc_pkg::step_t    step_reg;
    arpc_pkg::step_t    step_next;
    arpc_pkg::uc_word_t word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= arpc_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        word      = arpc_pkg::uc_rom(step_reg);
        step_next = step_reg;
        ctrl.op   = word.op;
        ctrl.emit = 1'b0;
        case (word.op)
            arpc_pkg::OP_WAIT:
            begin
                if (cond.in_fire)
                begin
                    step_next = word.tgt_a;
                end
            end
            arpc_pkg::OP_SCAN:
            begin
                if (cond.match)
                begin
                    step_next = word.tgt_a;
                end
                else if (cond.last)
                begin
                    step_next = cond.add ? word.tgt_c : word.tgt_b;
                end
            end
            arpc_pkg::OP_EMIT_HIT, arpc_pkg::OP_EMIT_MISS, arpc_pkg::OP_EMIT_EVICT:
            begin
                if (cond.out_free)
                begin
                    ctrl.emit = 1'b1;
                    step_next = word.tgt_a;
                end
            end
            default:
            begin
                step_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/arp_cache_oldest_replace.sv]
// top level of the arp cache: scan datapath, result register, sequencer and table
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+----------------------------------------
//  input    | in        | in_valid / in_stall  | mode, ip_address, mac_address, now_ms
//  output   | out       | out_valid / out_stall| found, mac_out, slot_index
//
// one word accepted when idle; entries are checked one per cycle in index order
// a scan that stops at slot k ends in a hit step, one that reaches the last slot
// with no match in a miss step for a lookup or an evict step for an add; that step
// registers the result, and the next word can be taken in the idle step after it
// reset clears the valid bits of all entries at once, so every slot reads empty
// out_stall holds the result register; the final step waits until it is free
module arp_cache_oldest_replace #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [arpc_pkg::IP_W-1:0]   ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]  mac_address,
    input  logic [arpc_pkg::TIME_W-1:0] now_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [arpc_pkg::MAC_W-1:0]  mac_out,
    output logic [arpc_pkg::SLOT_W-1:0] slot_index
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    arpc_pkg::cond_t cond;
    arpc_pkg::ctrl_t ctrl;

    logic                        mode_reg;
    logic [arpc_pkg::IP_W-1:0]   ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_reg;
    logic [arpc_pkg::TIME_W-1:0] now_reg;

    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               idx_next;
    logic [IW-1:0]               oldest_reg;
    logic [IW-1:0]               oldest_next;
    logic [arpc_pkg::TIME_W-1:0] oldest_time_reg;
    logic [arpc_pkg::TIME_W-1:0] oldest_time_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic                        found_next;
    logic [arpc_pkg::MAC_W-1:0]  mac_out_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_out_next;
    logic [arpc_pkg::SLOT_W-1:0] slot_reg;
    logic [arpc_pkg::SLOT_W-1:0] slot_next;

    logic [arpc_pkg::IP_W-1:0]   rd_ip;
    logic [arpc_pkg::MAC_W-1:0]  rd_mac;
    logic [arpc_pkg::TIME_W-1:0] rd_time;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic                        in_fire;
    logic                        ip_eq;
    logic                        slot_empty;

    arpc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    arpc_table #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_next),
        .rd_ip   (rd_ip),
        .rd_mac  (rd_mac),
        .rd_time (rd_time),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_ip   (ip_reg),
        .wr_mac  (mac_reg),
        .wr_time (now_reg)
    );

    assign in_stall   = (ctrl.op != arpc_pkg::OP_WAIT);
    assign in_fire    = in_valid && !in_stall;
    assign ip_eq      = (rd_ip == ip_reg);
    assign slot_empty = (rd_ip == '0);

    assign cond.in_fire  = in_fire;
    assign cond.match    = mode_reg ? (ip_eq || slot_empty) : ip_eq;
    assign cond.last     = (idx_reg == LAST_IDX);
    assign cond.add      = mode_reg;
    assign cond.out_free = !out_valid_reg || !out_stall;

    assign wr_en   = ctrl.emit && ((ctrl.op == arpc_pkg::OP_EMIT_EVICT) ||
                     ((ctrl.op == arpc_pkg::OP_EMIT_HIT) && mode_reg));
    assign wr_addr = (ctrl.op == arpc_pkg::OP_EMIT_EVICT) ? oldest_reg : idx_reg;

    always_comb
    begin
        idx_next         = idx_reg;
        oldest_next      = oldest_reg;
        oldest_time_next = oldest_time_reg;
        found_next       = found_reg;
        mac_out_next     = mac_out_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg && out_stall;
        case (ctrl.op)
            arpc_pkg::OP_WAIT:
            begin
                idx_next = '0;
            end
            arpc_pkg::OP_SCAN:
            begin
                // oldest tracking, first slot seeds it
                if ((idx_reg == '0) || (rd_time < oldest_time_reg))
                begin
                    oldest_next      = idx_reg;
                    oldest_time_next = rd_time;
                end
                if (!cond.match && !cond.last)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            arpc_pkg::OP_EMIT_HIT:
            begin
                if (ctrl.emit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    mac_out_next   = mode_reg ? '0 : rd_mac;
                    slot_next      = arpc_pkg::SLOT_W'(idx_reg);
                end
            end
            arpc_pkg::OP_EMIT_MISS:
            begin
                if (ctrl.emit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    mac_out_next   = '0;
                    slot_next      = '0;
                end
            end
            arpc_pkg::OP_EMIT_EVICT:
            begin
                if (ctrl.emit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    mac_out_next   = '0;
                    slot_next      = arpc_pkg::SLOT_W'(oldest_reg);
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode;
            ip_reg   <= ip_address;
            mac_reg  <= mac_address;
            now_reg  <= now_ms;
        end
        oldest_reg      <= oldest_next;
        oldest_time_reg <= oldest_time_next;
        found_reg       <= found_next;
        mac_out_reg     <= mac_out_next;
        slot_reg        <= slot_next;
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign mac_out    = mac_out_reg;
    assign slot_index = slot_reg;

endmodule

[rtl/arpc_checker.sv]
// port-level assertions for the arp cache and their bind
`include "assert_macros.svh"

module arpc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        found,
    input logic [arpc_pkg::MAC_W-1:0]  mac_out,
    input logic [arpc_pkg::SLOT_W-1:0] slot_index
);

    // stalled result word holds
    `ARPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(found) && $stable(mac_out) && $stable(slot_index),
        "stalled result changed")

    // a result without a hit never carries a mac
    `ARPC_ASSERT(a_miss_zero_mac, (out_valid && !found) |-> (mac_out == '0),
        "nonzero mac without hit")

    // busy right after a word is taken
    `ARPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input taken twice in a row")

    // no result can appear the cycle after accept
    `ARPC_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid),
        "result too early")

endmodule

bind arp_cache_oldest_replace arpc_checker u_arpc_checker (.*);
